// ----- rtl/chd_pkg.sv -----
package chd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned TABLE_LEN        = 24;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;

  localparam int unsigned Z_W = 26;
  localparam int unsigned H_W = 16;

  localparam logic signed [Z_W-1:0] ANGLE_180   = 26'sd11796480;
  localparam logic signed [Z_W-1:0] ROUND_HALF  = 26'sd256;
  localparam logic signed [H_W:0]   HEADING_MAX = 17'sd23040;

  typedef logic signed [Z_W-1:0] angle_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic angle_t atan_q16(input int unsigned idx);
    case (idx)
      0:       return 26'sd2949120;
      1:       return 26'sd1740967;
      2:       return 26'sd919879;
      3:       return 26'sd466945;
      4:       return 26'sd234379;
      5:       return 26'sd117304;
      6:       return 26'sd58666;
      7:       return 26'sd29335;
      8:       return 26'sd14668;
      9:       return 26'sd7334;
      10:      return 26'sd3667;
      11:      return 26'sd1833;
      12:      return 26'sd917;
      13:      return 26'sd458;
      14:      return 26'sd229;
      15:      return 26'sd115;
      16:      return 26'sd57;
      17:      return 26'sd29;
      18:      return 26'sd14;
      19:      return 26'sd7;
      20:      return 26'sd4;
      21:      return 26'sd2;
      22:      return 26'sd1;
      default: return 26'sd0;
    endcase
  endfunction

endpackage

// ----- rtl/compass_heading_atan2_unit.sv -----
// Planar compass heading: subtracts the hard-iron offsets from each
// two-axis sample and returns atan2(y, x) in degrees with 7 fraction bits
// (-23040..23040 means -180..+180), plus a flag for a zero corrected vector,
// which reads as heading 0. One sample is taken every cycle while the
// output is not stalled. The pipeline holds one stage for the offset
// subtract, one for prescale and half-plane fold, one per CORDIC iteration
// (a single adder stage each, CORDIC_STEPS capped at 24), and one for
// rounding and clamping. A stalled output freezes the whole pipeline.
// Offsets may be rewritten only while no sample is in flight.
module compass_heading_atan2_unit #(
  parameter int unsigned SAMPLE_BITS  = chd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = chd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [chd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]           cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]    mag_x_i,
  input  logic signed [SAMPLE_BITS-1:0]    mag_y_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [chd_pkg::H_W-1:0]   heading_o,
  output logic                             zero_vector_o
);
  import chd_pkg::*;

  localparam int unsigned NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int unsigned D_W   = SAMPLE_BITS + 1;
  localparam int unsigned W     = SAMPLE_BITS + 12;

  logic                        en;
  logic signed [SAMPLE_BITS-1:0] off_x_q, off_y_q;

  logic                        v_sub_q;
  logic signed [D_W-1:0]       dx_q, dy_q;
  logic signed [D_W-1:0]       dx_d, dy_d;

  logic                        v_q  [0:NSTEP];
  logic                        zv_q [0:NSTEP];
  logic signed [W-1:0]         x_q  [0:NSTEP];
  logic signed [W-1:0]         y_q  [0:NSTEP];
  angle_t                      z_q  [0:NSTEP];
  logic signed [W-1:0]         x_d  [0:NSTEP];
  logic signed [W-1:0]         y_d  [0:NSTEP];
  angle_t                      z_d  [0:NSTEP];

  logic signed [W-1:0]         xp, yp;
  angle_t                      z_round;
  logic signed [H_W:0]         h_raw;
  logic signed [H_W-1:0]       heading_d;
  logic                        out_valid_q, zero_q;
  logic signed [H_W-1:0]       heading_q;

  assign en         = out_ready_i || !out_valid_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET_X: off_x_q <= cfg_wdata_i;
        REG_OFFSET_Y: off_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign dx_d = $signed({mag_x_i[SAMPLE_BITS-1], mag_x_i})
              - $signed({off_x_q[SAMPLE_BITS-1], off_x_q});
  assign dy_d = $signed({mag_y_i[SAMPLE_BITS-1], mag_y_i})
              - $signed({off_y_q[SAMPLE_BITS-1], off_y_q});

  // prescale by 256 and fold the left half plane, then advance each iteration
  always_comb begin
    xp = {{(W-D_W-8){dx_q[D_W-1]}}, dx_q, 8'b0};
    yp = {{(W-D_W-8){dy_q[D_W-1]}}, dy_q, 8'b0};
    if (dx_q < 0) begin
      x_d[0] = -xp;
      y_d[0] = -yp;
      z_d[0] = (dy_q >= 0) ? ANGLE_180 : -ANGLE_180;
    end else begin
      x_d[0] = xp;
      y_d[0] = yp;
      z_d[0] = '0;
    end
    for (int unsigned i = 0; i < NSTEP; i++) begin
      if (y_q[i] > 0) begin
        x_d[i+1] = x_q[i] + (y_q[i] >>> i);
        y_d[i+1] = y_q[i] - (x_q[i] >>> i);
        z_d[i+1] = z_q[i] + atan_q16(i);
      end else begin
        x_d[i+1] = x_q[i] - (y_q[i] >>> i);
        y_d[i+1] = y_q[i] + (x_q[i] >>> i);
        z_d[i+1] = z_q[i] - atan_q16(i);
      end
    end
  end

  always_comb begin
    z_round = z_q[NSTEP] + ROUND_HALF;
    h_raw   = z_round[Z_W-1:9];
    if (zv_q[NSTEP]) begin
      heading_d = '0;
    end else if (h_raw > HEADING_MAX) begin
      heading_d = HEADING_MAX[H_W-1:0];
    end else if (h_raw < -HEADING_MAX) begin
      heading_d = 16'(-HEADING_MAX);
    end else begin
      heading_d = h_raw[H_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_sub_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int unsigned i = 0; i <= NSTEP; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en) begin
      v_sub_q <= in_valid_i;
      v_q[0]  <= v_sub_q;
      for (int unsigned i = 1; i <= NSTEP; i++) begin
        v_q[i] <= v_q[i-1];
      end
      out_valid_q <= v_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      zv_q[0] <= (dx_q == 0) && (dy_q == 0);
      for (int unsigned i = 0; i <= NSTEP; i++) begin
        x_q[i] <= x_d[i];
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
      end
      for (int unsigned i = 1; i <= NSTEP; i++) begin
        zv_q[i] <= zv_q[i-1];
      end
      heading_q <= heading_d;
      zero_q    <= zv_q[NSTEP];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign heading_o     = heading_q;
  assign zero_vector_o = zero_q;

  a_zero_heading : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_vector_o) |-> (heading_o == '0))
    else $error("zero vector with nonzero heading");

  a_heading_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((heading_o <= 16'sd23040) && (heading_o >= -16'sd23040)))
    else $error("heading out of range");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

// ----- test/compass_heading_atan2_unit_test.sv -----
module compass_heading_atan2_unit_test;
  import chd_pkg::*;

  localparam int unsigned STEPS = CORDIC_STEPS_DEF;
  localparam int unsigned ITERS = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
  localparam int unsigned LATENCY = ITERS + 3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PCT = 17;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam longint DEG180_Q16 = 64'sd11796480;
  localparam longint HEADING_LIMIT = 64'sd23040;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct packed {
    logic signed [H_W-1:0] heading;
    logic                  zero_vector;
  } heading_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = REG_OFFSET_X;
  logic [SAMPLE_BITS_DEF-1:0] cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  sample_t                  mag_x_i = '0;
  sample_t                  mag_y_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [H_W-1:0]    heading_o;
  logic                     zero_vector_o;

  longint atan_deg_q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  sample_t         hard_iron_x = '0;
  sample_t         hard_iron_y = '0;
  heading_result_t expected_headings[$];
  bit              idle_on = 1'b1;
  int unsigned     mismatch_count = 0;
  int unsigned     samples_sent = 0;
  int unsigned     zero_vectors_sent = 0;
  int unsigned     offset_writes = 0;
  int unsigned     headings_checked = 0;
  int unsigned     stall_cycles = 0;

  compass_heading_atan2_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mag_x_i       (mag_x_i),
    .mag_y_i       (mag_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .heading_o     (heading_o),
    .zero_vector_o (zero_vector_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic heading_result_t predict_heading(input sample_t mx, input sample_t my);
    heading_result_t r;
    longint cx;
    longint cy;
    longint z;
    longint xs;
    longint ys;
    longint h;
    int unsigned i;
    cx = longint'(mx) - longint'(hard_iron_x);
    cy = longint'(my) - longint'(hard_iron_y);
    z = 0;
    r.heading = '0;
    r.zero_vector = 1'b0;
    if (cx == 0 && cy == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    cx = cx * 256;
    cy = cy * 256;
    if (cx < 0) begin
      z = (cy >= 0) ? DEG180_Q16 : -DEG180_Q16;
      cx = -cx;
      cy = -cy;
    end
    for (i = 0; i < ITERS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy > 0) begin
        cx = cx + ys;
        cy = cy - xs;
        z = z + atan_deg_q16[i];
      end else begin
        cx = cx - ys;
        cy = cy + xs;
        z = z - atan_deg_q16[i];
      end
    end
    h = (z + 256) >>> 9;
    if (h > HEADING_LIMIT) h = HEADING_LIMIT;
    if (h < -HEADING_LIMIT) h = -HEADING_LIMIT;
    r.heading = h[H_W-1:0];
    return r;
  endfunction

  task automatic send_sample(input sample_t mx, input sample_t my);
    heading_result_t exp_r;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mag_x_i <= mx;
    mag_y_i <= my;
    do @(posedge clk_i); while (!in_ready_o);
    exp_r = predict_heading(mx, my);
    expected_headings.push_back(exp_r);
    samples_sent++;
    if (exp_r.zero_vector) zero_vectors_sent++;
  endtask

  // drop valid and hold until every pending heading has been checked
  task automatic wait_all_headings();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_headings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input sample_t value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == REG_OFFSET_X) hard_iron_x = value;
    else if (idx == REG_OFFSET_Y) hard_iron_y = value;
    offset_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic sample_t pick_component(input sample_t offset);
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      6:       return offset + sample_t'($urandom_range(8)) - sample_t'(4);
      7:       return $urandom_range(1) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000);
      8:       return offset;
      9:       return sample_t'($urandom_range(15)) - sample_t'(8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic test_axes_and_extremes();
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd5, 16'sd0);
    send_sample(-16'sd5, -16'sd1);
    send_sample(-16'sd5, 16'sd1);
    send_sample(16'sd7, 16'sd0);
    send_sample(16'sd0, 16'sd9);
    send_sample(16'sd0, -16'sd9);
    send_sample(16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sd1, -16'sd1);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sd0);
    send_sample(16'sd0, 16'sh8000);
    wait_all_headings();
  endtask

  task automatic test_offset_extremes();
    write_reg(REG_OFFSET_X, 16'sh7fff);
    write_reg(REG_OFFSET_Y, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    wait_all_headings();
    // spare indexes must leave both offsets alone
    write_reg(REG_SPARE_A, 16'sh1234);
    write_reg(REG_SPARE_B, 16'shedcb);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
    wait_all_headings();
  endtask

  task automatic test_random_phases();
    int unsigned ph;
    int unsigned n;
    for (ph = 0; ph < 8; ph++) begin
      wait_all_headings();
      case (ph)
        0: begin
          write_reg(REG_OFFSET_X, '0);
          write_reg(REG_OFFSET_Y, '0);
        end
        1: begin
          write_reg(REG_OFFSET_X, 16'sh7fff);
          write_reg(REG_OFFSET_Y, 16'sh8000);
        end
        2: begin
          write_reg(REG_OFFSET_X, 16'sh8000);
          write_reg(REG_OFFSET_Y, 16'sh7fff);
        end
        default: begin
          write_reg(REG_OFFSET_X, sample_t'($urandom));
          write_reg(REG_OFFSET_Y, sample_t'($urandom));
          if (ph == 5) write_reg(REG_SPARE_A, sample_t'($urandom));
          if (ph == 6) write_reg(REG_SPARE_B, sample_t'($urandom));
        end
      endcase
      idle_on = (ph != 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) wait_all_headings();
        send_sample(pick_component(hard_iron_x), pick_component(hard_iron_y));
      end
    end
    idle_on = 1'b1;
    wait_all_headings();
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    heading_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_headings.size() == 0) begin
        $display("%0t unexpected heading transfer: expected none, actual heading %0d zero %0b",
                 $time, heading_o, zero_vector_o);
        mismatch_count++;
      end else begin
        exp_r = expected_headings.pop_front();
        headings_checked++;
        if (heading_o !== exp_r.heading) begin
          $display("%0t heading: expected %0d actual %0d", $time, exp_r.heading, heading_o);
          mismatch_count++;
        end
        if (zero_vector_o !== exp_r.zero_vector) begin
          $display("%0t zero_vector: expected %0b actual %0b",
                   $time, exp_r.zero_vector, zero_vector_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $time, stall_cycles);
      $display("compass_heading_atan2_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_axes_and_extremes();
    test_offset_extremes();
    test_random_phases();
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("%0d samples sent, %0d headings checked, %0d zero vectors, %0d register writes",
             samples_sent, headings_checked, zero_vectors_sent, offset_writes);
    $display("offsets at zero, both extremes and random values; spare indexes written");
    if (mismatch_count == 0) begin
      $display("compass_heading_atan2_unit: match");
    end else begin
      $display("compass_heading_atan2_unit: mismatch");
    end
    $finish;
  end

endmodule
